// ===== src/cosine_sum_window_generator_unit_assert.svh =====
// assertion macros for the cosine-sum window generator checker
`ifndef COSINE_SUM_WINDOW_GENERATOR_UNIT_ASSERT_SVH
`define COSINE_SUM_WINDOW_GENERATOR_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CSWG_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cswg assertion failed");

// antecedent implies consequent after the delay given by n
`define CSWG_ASSERT_DELAY(label, ante, n, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error("cswg assertion failed");

`endif

// ===== src/cswg_pkg.sv =====
// shared constants for the cosine-sum window generator
`timescale 1ns / 1ps

package cswg_pkg;

   localparam int unsigned MAX_POINTS_DEFAULT = 4096;

   // register map, index = paddr[3:2]
   localparam logic [1:0] REG_KIND = 2'd0;
   localparam logic [1:0] REG_SIZE = 2'd1;
   localparam logic [1:0] REG_AMP  = 2'd2;

   localparam logic        KIND_RESET = 1'b0;
   localparam logic [12:0] SIZE_RESET = 13'd1024;
   localparam logic [15:0] AMP_RESET  = 16'd32768;

   localparam logic KIND_HANN     = 1'b0;
   localparam logic KIND_BLACKMAN = 1'b1;

   // q30 constants, with pi in q32 and a quarter turn in q0.24
   localparam logic [30:0] Q30_ONE = 31'd1073741824;
   localparam logic [33:0] PI_Q32  = 34'h3243F6A89;
   localparam logic [31:0] K_042   = 32'd450971566;
   localparam logic [31:0] K_050   = 32'd536870912;
   localparam logic [26:0] K_008   = 27'd85899346;
   localparam logic [22:0] QUARTER = 23'h400000;

   // taylor series divisors, one per horner step
   localparam int unsigned HORNER_STEPS = 7;
   localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{182, 132, 90, 56, 30, 12, 2};

   // phase divider: 36 numerator bits, four bits per stage
   localparam int unsigned NUM_W         = 36;
   localparam int unsigned DIV_BITS      = 4;
   localparam int unsigned DIV_STAGES    = NUM_W / DIV_BITS;
   localparam int unsigned COS_LATENCY   = 4 + 3 * HORNER_STEPS;
   // register stages between an accepted request and its result
   localparam int unsigned PIPE_LATENCY  = DIV_STAGES + 1 + COS_LATENCY + 4;

endpackage

// ===== src/cswg_cos.sv =====
// pipelined cosine of a q0.24 turn, signed q30 result
`timescale 1ns / 1ps

module cswg_cos
   import cswg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [23:0]        in_phase,
   output logic               out_valid,
   output logic signed [31:0] out_cos
);

   typedef struct packed {
      logic        valid;
      logic        neg;
      logic [31:0] t2;
   } side_type;

   // fold stage
   logic        v0_ff, neg0_ff;
   logic [22:0] rr0_ff;
   logic [22:0] rr_in;
   logic        neg_in;

   always_comb begin
      rr_in  = in_phase[22] ? (QUARTER - {1'b0, in_phase[21:0]}) : {1'b0, in_phase[21:0]};
      neg_in = in_phase[23] ^ in_phase[22];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
      end
      neg0_ff <= neg_in;
      rr0_ff  <= rr_in;
   end

   // angle in q30 radians
   logic        v1_ff, neg1_ff;
   logic [30:0] t1_ff;
   logic [56:0] t_prod;

   assign t_prod = 57'(rr0_ff) * 57'(PI_Q32) + 57'(25'h1000000);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      neg1_ff <= neg0_ff;
      t1_ff   <= t_prod[55:25];
   end

   // squared angle
   side_type    side2_ff;
   logic [62:0] tt_prod;

   assign tt_prod = 63'(t1_ff) * 63'(t1_ff) + 63'(30'h20000000);

   always_ff @(posedge clock) begin
      if (reset) begin
         side2_ff.valid <= 1'b0;
      end else begin
         side2_ff.valid <= v1_ff;
      end
      side2_ff.neg <= neg1_ff;
      side2_ff.t2  <= tt_prod[61:30];
   end

   // horner steps, three stages each
   side_type    sa_ff [HORNER_STEPS];
   side_type    sb_ff [HORNER_STEPS];
   side_type    sc_ff [HORNER_STEPS];
   logic [31:0] xa_ff [HORNER_STEPS];
   logic [31:0] xb_ff [HORNER_STEPS];
   logic [31:0] q0_ff [HORNER_STEPS];
   logic [30:0] b_ff  [HORNER_STEPS];

   for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
      localparam logic [31:0] DIV   = 32'(HORNER_DIV[k]);
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / HORNER_DIV[k]);

      side_type    s_in;
      logic [30:0] b_in;
      logic [62:0] px;
      logic [63:0] py;
      logic [32:0] rem;
      logic [31:0] q;
      logic [30:0] b_next;

      if (k == 0) begin : g_first
         assign s_in = side2_ff;
         assign b_in = Q30_ONE;
      end else begin : g_next
         assign s_in = sc_ff[k-1];
         assign b_in = b_ff[k-1];
      end

      assign px = 63'(s_in.t2) * 63'(b_in);
      assign py = 64'(xa_ff[k]) * 64'(RECIP);

      // reciprocal quotient is low by at most one
      always_comb begin
         rem    = 33'(xb_ff[k]) - 33'(q0_ff[k]) * 33'(DIV);
         q      = q0_ff[k] + 32'(rem >= 33'(DIV));
         b_next = (q >= 32'(Q30_ONE)) ? 31'd0 : (Q30_ONE - q[30:0]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sa_ff[k].valid <= 1'b0;
            sb_ff[k].valid <= 1'b0;
            sc_ff[k].valid <= 1'b0;
         end else begin
            sa_ff[k].valid <= s_in.valid;
            sb_ff[k].valid <= sa_ff[k].valid;
            sc_ff[k].valid <= sb_ff[k].valid;
         end
         sa_ff[k].neg <= s_in.neg;
         sa_ff[k].t2  <= s_in.t2;
         sb_ff[k].neg <= sa_ff[k].neg;
         sb_ff[k].t2  <= sa_ff[k].t2;
         sc_ff[k].neg <= sb_ff[k].neg;
         sc_ff[k].t2  <= sb_ff[k].t2;
         xa_ff[k]     <= px[61:30];
         xb_ff[k]     <= xa_ff[k];
         q0_ff[k]     <= py[63:32];
         b_ff[k]      <= b_next;
      end
   end

   // sign restore
   logic               out_valid_ff;
   logic signed [31:0] out_cos_ff;
   logic signed [31:0] cos_in;

   assign cos_in = sc_ff[HORNER_STEPS-1].neg ? -$signed({1'b0, b_ff[HORNER_STEPS-1]})
                                              : $signed({1'b0, b_ff[HORNER_STEPS-1]});

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= sc_ff[HORNER_STEPS-1].valid;
      end
      out_cos_ff <= cos_in;
   end

   assign out_valid = out_valid_ff;
   assign out_cos   = out_cos_ff;

endmodule

// ===== src/cosine_sum_window_generator_unit.sv =====
// hann / blackman window coefficient generator, top level
// pipeline: 39 register stages from request transfer to result transfer
// throughput: one request per cycle outside reset, fully pipelined; the receiver cannot stall
// stages: input register, 9 divider stages, 25 per cosine unit, 4 scale/sum/gain/round
// reset: synchronous, clears all stage valid bits and loads register defaults
// busy is high only while reset is asserted
`timescale 1ns / 1ps

module cosine_sum_window_generator_unit
   import cswg_pkg::*;
#(
   parameter int unsigned MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic [11:0]        req_sample_index,
   // result channel
   output logic               rsp_valid,
   output logic signed [17:0] rsp_window_value,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // divisor width, d = size - 1 < MAX_POINTS
   localparam int DW = $clog2(MAX_POINTS);

   typedef struct packed {
      logic             valid;
      logic [DW-1:0]    rem;
      logic [NUM_W-1:0] num;
      logic [23:0]      quo;
   } div_type;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic        kind_ff;
   logic [12:0] size_ff;
   logic [15:0] amp_ff;
   logic        wr_en;

   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_RESET;
         size_ff <= SIZE_RESET;
         amp_ff  <= AMP_RESET;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_KIND: kind_ff <= pwdata[0];
            REG_SIZE: size_ff <= pwdata[12:0];
            REG_AMP:  amp_ff  <= pwdata[15:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_KIND: prdata = {31'd0, kind_ff};
         REG_SIZE: prdata = {19'd0, size_ff};
         REG_AMP:  prdata = {16'd0, amp_ff};
         default:  prdata = 32'd0;
      endcase
   end

   // requests are refused only during reset
   assign busy = reset;

   // ---------------------------------------------------------------
   // phase = round(index * 2^24 / d) mod 2^24, by long division
   // ---------------------------------------------------------------
   logic [16:0]   size_clamp;
   logic [DW-1:0] d_val;
   logic [DW-1:0] h_val;

   // size below two counts as two, above the limit as the limit
   always_comb begin
      if (size_ff < 13'd2) begin
         size_clamp = 17'd2;
      end else if (32'(size_ff) > 32'(MAX_POINTS)) begin
         size_clamp = 17'(MAX_POINTS);
      end else begin
         size_clamp = 17'(size_ff);
      end
      d_val = DW'(size_clamp - 17'd1);
      h_val = d_val >> 1;
   end

   // four restoring steps; only the low 24 quotient bits are kept (mod one turn)
   function automatic div_type div_step(div_type s, logic [DW-1:0] d);
      div_type res;
      logic [DW:0] r2;
      logic        qb;
      res = s;
      for (int i = 0; i < DIV_BITS; i++) begin
         r2      = {res.rem, res.num[NUM_W-1]};
         res.num = {res.num[NUM_W-2:0], 1'b0};
         if (r2 >= {1'b0, d}) begin
            r2 = r2 - {1'b0, d};
            qb = 1'b1;
         end else begin
            qb = 1'b0;
         end
         res.rem = r2[DW-1:0];
         res.quo = {res.quo[22:0], qb};
      end
      return res;
   endfunction

   div_type div_ff [DIV_STAGES+1];
   div_type div_first_in;

   always_comb begin
      div_first_in.valid = start & ~busy;
      div_first_in.rem   = '0;
      // rounding offset d/2 sits in the low bits, clear of the index
      div_first_in.num   = {req_sample_index, 24'(h_val)};
      div_first_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff[0].valid <= 1'b0;
      end else begin
         div_ff[0].valid <= div_first_in.valid;
      end
      div_ff[0].rem <= div_first_in.rem;
      div_ff[0].num <= div_first_in.num;
      div_ff[0].quo <= div_first_in.quo;
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      div_type step_in;
      assign step_in = div_step(div_ff[s], d_val);

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[s+1].valid <= 1'b0;
         end else begin
            div_ff[s+1].valid <= step_in.valid;
         end
         div_ff[s+1].rem <= step_in.rem;
         div_ff[s+1].num <= step_in.num;
         div_ff[s+1].quo <= step_in.quo;
      end
   end

   // ---------------------------------------------------------------
   // cosines of the phase and of the double-angle phase
   // ---------------------------------------------------------------
   logic               c1_valid, c2_valid;
   logic signed [31:0] c1, c2;
   logic [23:0]        phase, phase2;

   assign phase  = div_ff[DIV_STAGES].quo;
   assign phase2 = {phase[22:0], 1'b0};

   cswg_cos u_cos1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_ff[DIV_STAGES].valid),
      .in_phase  (phase),
      .out_valid (c1_valid),
      .out_cos   (c1)
   );

   cswg_cos u_cos2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_ff[DIV_STAGES].valid),
      .in_phase  (phase2),
      .out_valid (c2_valid),
      .out_cos   (c2)
   );

   // ---------------------------------------------------------------
   // m1: scale the cosines, rounding ties away from zero
   // ---------------------------------------------------------------
   logic               m1_valid_ff;
   logic signed [31:0] a50_ff;
   logic [57:0]        p08_ff;
   logic               neg08_ff;
   logic [31:0]        mag1, mag2, half1;
   logic signed [31:0] a50_in;

   always_comb begin
      mag1   = c1[31] ? 32'(-c1) : 32'(c1);
      mag2   = c2[31] ? 32'(-c2) : 32'(c2);
      // times 0.5 in q30 is a rounded halving
      half1  = (mag1 + 32'd1) >> 1;
      a50_in = c1[31] ? -$signed(half1) : $signed(half1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= c1_valid & c2_valid;
      end
      a50_ff   <= a50_in;
      p08_ff   <= 58'(mag2[30:0]) * 58'(K_008);
      neg08_ff <= c2[31];
   end

   // ---------------------------------------------------------------
   // m2: sum of the cosine terms
   // ---------------------------------------------------------------
   logic               m2_valid_ff;
   logic signed [32:0] w_ff;
   logic [57:0]        r08;
   logic signed [32:0] s08;
   logic signed [32:0] w_in;

   always_comb begin
      r08 = p08_ff + 58'(30'h20000000);
      s08 = neg08_ff ? -$signed(33'(r08[57:30])) : $signed(33'(r08[57:30]));
      if (kind_ff == KIND_BLACKMAN) begin
         w_in = $signed(33'(K_042)) - 33'(a50_ff) + s08;
      end else begin
         w_in = $signed(33'(K_050)) - 33'(a50_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else begin
         m2_valid_ff <= m1_valid_ff;
      end
      w_ff <= w_in;
   end

   // ---------------------------------------------------------------
   // m3: apply the amplitude
   // ---------------------------------------------------------------
   logic        m3_valid_ff;
   logic [47:0] pw_ff;
   logic        negw_ff;
   logic [31:0] magw;

   assign magw = w_ff[32] ? 32'(-w_ff) : 32'(w_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else begin
         m3_valid_ff <= m2_valid_ff;
      end
      pw_ff   <= 48'(magw) * 48'(amp_ff);
      negw_ff <= w_ff[32];
   end

   // ---------------------------------------------------------------
   // m4: round to q2.15 into the result register
   // ---------------------------------------------------------------
   logic               rsp_valid_ff;
   logic signed [17:0] rsp_value_ff;
   logic [47:0]        rw;
   logic [17:0]        v18;
   logic signed [17:0] rsp_value_in;

   always_comb begin
      rw           = pw_ff + 48'(30'h20000000);
      v18          = rw[47:30];
      rsp_value_in = negw_ff ? -$signed(v18) : $signed(v18);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= m3_valid_ff;
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_value = rsp_value_ff;

endmodule

// ===== src/cswg_checker.sv =====
// port-level checker for the window generator, with its bind
`timescale 1ns / 1ps
`include "cosine_sum_window_generator_unit_assert.svh"

module cswg_checker
   import cswg_pkg::*;
#(
   parameter int unsigned LATENCY = PIPE_LATENCY
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [17:0] rsp_window_value
);

   // every request transfer yields a result at the end of the pipeline
   `CSWG_ASSERT_DELAY(a_rsp_after_req, start && !busy, LATENCY, rsp_valid)

   // no result without a request transfer at the matching time
   `CSWG_ASSERT_IMPLY(a_no_spurious_rsp, rsp_valid, $past(start && !busy, LATENCY))

   // coefficient times gain stays within +/-2.0 in q2.15
   `CSWG_ASSERT_IMPLY(a_value_range, rsp_valid,
                      rsp_window_value <= 18'sd65536 && rsp_window_value >= -18'sd65536)

endmodule

bind cosine_sum_window_generator_unit cswg_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_window_value (rsp_window_value)
);
